### rtl/imq_pkg.sv
// Shared types, codes and constants of the indexed max priority queue.
package imq_pkg;

  localparam int DefCapacity     = 64;
  localparam int DefPriorityBits = 16;
  localparam int EntryCount      = 64;
  localparam int EntryBits       = 6;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_DUP    = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, read position table
    logic check;      // decide status, start operation
    logic rd_parent;  // issue sift-up parent read
    logic up_step;    // compare with parent, move or stop
    logic rd_kids;    // issue sift-down child reads
    logic dn_step;    // compare with children, swap or stop
    logic rd_root;    // issue root and last reads for extract
    logic ext_step;   // perform extract bookkeeping
    logic finish;     // write final slot, build result
  } imq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] mode;
    logic       fail;      // request ends with error or no-op
    logic       up_more;   // sift-up has a parent to test
    logic       up_move;   // parent is smaller, keep going
    logic       dn_more;   // sift-down has a child to test
    logic       dn_move;   // a child is larger, keep going
  } imq_sts_t;

endpackage

### rtl/indexed_max_priority_queue.sv
// Top level of the indexed max priority queue.
// Usage:
//   Input channel in_*: one request per transaction, mode/index/priority in
//   in_tdata. Result channel out_*: one result per request, in order.
//   Each request runs in a controller and datapath pair: a check step, then
//   sift-up (insert), sift-down (extract) or both (change), each heap level
//   taking a heap read, then a compare and write; extract adds a root read
//   and a bookkeeping step; a final step writes the last slot and loads the
//   result register. A failed or unused request goes from the check straight
//   to the final step. One request is in flight at a time; in_tready rises
//   again in the cycle the result is loaded, and a new request is taken
//   while an older result still waits.
//   If the receiver stalls, the block holds the next finished result
//   until out_tready frees the register.
//   Reset empties the queue: the count clears and every entry reads as
//   absent at once; no clearing pass is needed.
module indexed_max_priority_queue
  import imq_pkg::*;
#(
  parameter int CAPACITY      = DefCapacity,
  parameter int PRIORITY_BITS = DefPriorityBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[1:0], entry_index[7:2], new_priority[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[2:0], out_index[8:3], out_priority[24:9],
                                  // occupancy[31:25]
);

  imq_cmd_t cmd;
  imq_sts_t sts;
  logic busy, in_fire, res_free;
  logic out_valid_r;
  logic [2:0] st;
  logic [EntryBits-1:0] oi;
  logic signed [15:0] op;
  logic [6:0] occ;
  logic signed [15:0] req_pr;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign res_free  = !out_valid_r || out_tready;
  assign req_pr    = 16'(signed'(in_tdata[8 +: PRIORITY_BITS]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  imq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .res_free (res_free),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  imq_dpath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_mode      (in_tdata[1:0]),
    .req_index     (in_tdata[7:2]),
    .req_priority  (req_pr),
    .sts           (sts),
    .res_status    (st),
    .res_index     (oi),
    .res_priority  (op),
    .res_occupancy (occ)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {occ, op, oi, st};

endmodule

### rtl/imq_ctrl.sv
// Controller state machine of the indexed max priority queue.
module imq_ctrl
  import imq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     res_free,
  input  imq_sts_t sts,
  output logic     busy,
  output imq_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_UPRD   = 4'd2;
  localparam logic [3:0] S_UPCMP  = 4'd3;
  localparam logic [3:0] S_DNRD   = 4'd4;
  localparam logic [3:0] S_DNCMP  = 4'd5;
  localparam logic [3:0] S_EXRD   = 4'd6;
  localparam logic [3:0] S_EXSTEP = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.fail) begin
          state_nxt = S_FIN;
        end else if (sts.mode == MODE_EXTRACT) begin
          state_nxt = S_EXRD;
        end else begin
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (sts.up_more) begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UPCMP;
        end else if (sts.mode == MODE_CHANGE) begin
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UPCMP: begin
        cmd.up_step = 1'b1;
        if (sts.up_move) begin
          state_nxt = S_UPRD;
        end else if (sts.mode == MODE_CHANGE) begin
          state_nxt = S_DNRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EXRD: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_EXSTEP;
      end
      S_EXSTEP: begin
        cmd.ext_step = 1'b1;
        state_nxt    = S_DNRD;
      end
      S_DNRD: begin
        if (sts.dn_more) begin
          cmd.rd_kids = 1'b1;
          state_nxt   = S_DNCMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DNCMP: begin
        cmd.dn_step = 1'b1;
        state_nxt   = sts.dn_move ? S_DNRD : S_FIN;
      end
      S_FIN: begin
        if (res_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_IDLE))
    else $error("finish must return controller to idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(cmd.up_step || cmd.dn_step || cmd.finish))
    else $error("datapath step issued while idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_CHECK))
    else $error("load must be followed by check");

endmodule

### rtl/imq_dpath.sv
// Datapath of the indexed max priority queue: heap memories, position table, result.
module imq_dpath
  import imq_pkg::*;
#(
  parameter int CAPACITY      = DefCapacity,
  parameter int PRIORITY_BITS = DefPriorityBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  imq_cmd_t             cmd,
  input  logic [1:0]           req_mode,
  input  logic [EntryBits-1:0] req_index,
  input  logic signed [15:0]   req_priority,
  output imq_sts_t             sts,
  output logic [2:0]           res_status,
  output logic [EntryBits-1:0] res_index,
  output logic signed [15:0]   res_priority,
  output logic [6:0]           res_occupancy
);

  localparam int SB = $clog2(CAPACITY);
  localparam int PB = $clog2(CAPACITY + 1);
  localparam int PRB = PRIORITY_BITS;

  typedef logic [PB-1:0]         pos_t;
  typedef logic signed [PRB-1:0] prio_t;

  // Heap memories: one write port, two read ports with registered data.
  logic [EntryBits-1:0] mem_idx [CAPACITY];
  prio_t                mem_pr  [CAPACITY];
  // Position table: one write port, one read port.
  pos_t                 pos_mem [EntryCount];
  logic [EntryCount-1:0] pos_vld_r;

  logic                 wr_en;
  logic [SB-1:0]        wr_addr;
  logic [EntryBits-1:0] wr_idx;
  prio_t                wr_pr;
  logic                 rd_en;
  logic [SB-1:0]        ra_addr, rb_addr;
  logic [EntryBits-1:0] ra_idx_r, rb_idx_r;
  prio_t                ra_pr_r, rb_pr_r;

  logic                 pw_en;
  logic [EntryBits-1:0] pw_addr, pw2_addr;
  pos_t                 pw_val;
  logic                 pw_clr;
  logic [EntryBits-1:0] pr_addr;
  pos_t                 pos_rd_r;
  logic                 pos_vld_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_idx[wr_addr] <= wr_idx;
      mem_pr[wr_addr]  <= wr_pr;
    end
    if (rd_en) begin
      ra_idx_r <= mem_idx[ra_addr];
      ra_pr_r  <= mem_pr[ra_addr];
      rb_idx_r <= mem_idx[rb_addr];
      rb_pr_r  <= mem_pr[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) pos_mem[pw_addr] <= pw_val;
    pos_rd_r     <= pos_mem[pr_addr];
    pos_vld_rd_r <= pos_vld_r[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r <= '0;
    end else begin
      if (pw_en)  pos_vld_r[pw_addr]  <= 1'b1;
      if (pw_clr) pos_vld_r[pw2_addr] <= 1'b0;
    end
  end

  logic [1:0]           mode_r;
  logic [EntryBits-1:0] idx_r;
  prio_t                pr_r;
  pos_t                 count_r, count_nxt;
  pos_t                 cur_r, cur_nxt;
  logic [2:0]           st_r, st_nxt;
  logic                 fail_r, fail_nxt;
  logic [EntryBits-1:0] oi_r, oi_nxt;
  prio_t                op_r, op_nxt;
  logic [EntryBits-1:0] hold_idx_r, hold_idx_nxt;
  prio_t                hold_pr_r, hold_pr_nxt;
  logic                 rchild_ok_r;

  pos_t parent, lchild, rchild;
  logic present;
  pos_t cur_pos;

  assign cur_pos = pos_vld_rd_r ? pos_rd_r : pos_t'(CAPACITY);
  assign present = cur_pos < count_r;
  assign parent  = (cur_r - pos_t'(1)) >> 1;
  assign lchild  = pos_t'({cur_r, 1'b1});
  assign rchild  = pos_t'(lchild + pos_t'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fail_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= req_mode;
      idx_r  <= req_index;
      pr_r   <= prio_t'(req_priority);
    end
    if (cmd.rd_kids) rchild_ok_r <= rchild < count_r;
    cur_r      <= cur_nxt;
    st_r       <= st_nxt;
    oi_r       <= oi_nxt;
    op_r       <= op_nxt;
    hold_idx_r <= hold_idx_nxt;
    hold_pr_r  <= hold_pr_nxt;
  end

  logic                 lbig, rbig;
  logic [SB-1:0]        big_slot;
  logic [EntryBits-1:0] big_idx;
  prio_t                big_pr;

  always_comb begin
    lbig     = ra_pr_r > hold_pr_r;
    rbig     = rchild_ok_r && (rb_pr_r > (lbig ? ra_pr_r : hold_pr_r));
    big_slot = rbig ? SB'(rchild) : SB'(lchild);
    big_idx  = rbig ? rb_idx_r : ra_idx_r;
    big_pr   = rbig ? rb_pr_r : ra_pr_r;
  end

  always_comb begin
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    st_nxt       = st_r;
    fail_nxt     = fail_r;
    oi_nxt       = oi_r;
    op_nxt       = op_r;
    hold_idx_nxt = hold_idx_r;
    hold_pr_nxt  = hold_pr_r;
    wr_en = 1'b0; wr_addr = '0; wr_idx = hold_idx_r; wr_pr = hold_pr_r;
    rd_en = 1'b0; ra_addr = '0; rb_addr = '0;
    pw_en = 1'b0; pw_addr = hold_idx_r; pw_val = cur_r;
    pw2_addr = '0; pw_clr = 1'b0;
    pr_addr = req_index;

    if (cmd.check) begin
      st_nxt       = ST_OK;
      fail_nxt     = 1'b0;
      oi_nxt       = '0;
      op_nxt       = '0;
      hold_idx_nxt = idx_r;
      hold_pr_nxt  = pr_r;
      unique case (mode_r)
        MODE_INSERT: begin
          if (present) begin
            st_nxt = ST_DUP; fail_nxt = 1'b1;
          end else if (count_r >= pos_t'(CAPACITY)) begin
            st_nxt = ST_FULL; fail_nxt = 1'b1;
          end else begin
            cur_nxt   = count_r;
            count_nxt = count_r + pos_t'(1);
          end
        end
        MODE_EXTRACT: begin
          if (count_r == '0) begin
            st_nxt = ST_EMPTY; fail_nxt = 1'b1;
          end
        end
        MODE_CHANGE: begin
          if (!present) begin
            st_nxt = ST_ABSENT; fail_nxt = 1'b1;
          end else begin
            cur_nxt = cur_pos;
          end
        end
        default: fail_nxt = 1'b1;
      endcase
    end

    if (cmd.rd_parent) begin
      rd_en   = 1'b1;
      ra_addr = SB'(parent);
    end

    if (cmd.up_step) begin
      if (ra_pr_r < hold_pr_r) begin
        wr_en   = 1'b1;
        wr_addr = SB'(cur_r);
        wr_idx  = ra_idx_r;
        wr_pr   = ra_pr_r;
        pw_en   = 1'b1;
        pw_addr = ra_idx_r;
        pw_val  = cur_r;
        cur_nxt = parent;
      end
    end

    if (cmd.rd_root) begin
      rd_en   = 1'b1;
      ra_addr = '0;
      rb_addr = SB'(count_r - pos_t'(1));
    end

    if (cmd.ext_step) begin
      oi_nxt       = ra_idx_r;
      op_nxt       = ra_pr_r;
      hold_idx_nxt = rb_idx_r;
      hold_pr_nxt  = rb_pr_r;
      count_nxt    = count_r - pos_t'(1);
      cur_nxt      = '0;
      pw2_addr     = ra_idx_r;
      pw_clr       = 1'b1;
    end

    if (cmd.rd_kids) begin
      rd_en   = 1'b1;
      ra_addr = SB'(lchild);
      rb_addr = SB'(rchild);
    end

    if (cmd.dn_step) begin
      if (lbig || rbig) begin
        wr_en   = 1'b1;
        wr_addr = SB'(cur_r);
        wr_idx  = big_idx;
        wr_pr   = big_pr;
        pw_en   = 1'b1;
        pw_addr = big_idx;
        pw_val  = cur_r;
        cur_nxt = pos_t'(big_slot);
      end
    end

    if (cmd.finish) begin
      if (!fail_r && !(mode_r == MODE_EXTRACT && count_r == '0)) begin
        wr_en   = 1'b1;
        wr_addr = SB'(cur_r);
        pw_en   = 1'b1;
      end
    end
  end

  logic [EntryBits-1:0] res_idx_r;
  logic signed [15:0]   res_pr_r;
  logic [2:0]           res_st_r;
  logic [6:0]           res_occ_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_st_r  <= st_r;
      res_idx_r <= oi_r;
      res_pr_r  <= 16'(unsigned'(op_r));
      res_occ_r <= 7'(count_r);
    end
  end

  assign res_status    = res_st_r;
  assign res_index     = res_idx_r;
  assign res_priority  = res_pr_r;
  assign res_occupancy = res_occ_r;

  assign sts.mode    = mode_r;
  assign sts.fail    = fail_nxt;
  assign sts.up_more = cur_r != '0;
  assign sts.up_move = ra_pr_r < hold_pr_r;
  assign sts.dn_more = lchild < count_r;
  assign sts.dn_move = lbig || rbig;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pos_t'(CAPACITY))
    else $error("heap count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.up_step |-> (cur_r != '0))
    else $error("sift-up step at root");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ext_step) |-> (count_r != '0))
    else $error("extract on empty heap");

endmodule
